FILE: rtl/core/rspp_pkg.sv
// ----------------------------------------------------------------------------
// rspp_pkg: shared types and constants of the sensor packet parser
// Event codes, sub-payload ids, the queue entry layout and the length check.
// ----------------------------------------------------------------------------
package rspp_pkg;

  // Result event codes
  typedef enum logic [1:0] {
    EV_BASIC   = 2'd0,
    EV_CLIFF   = 2'd1,
    EV_LEN_ERR = 2'd2,
    EV_END     = 2'd3
  } event_t;

  // Record bytes kept per sub-payload (the last byte of a basic record is unused)
  localparam int RecBytes = 14;
  localparam int RecIdxW  = $clog2(RecBytes);

  // Sub-payload ids
  localparam logic [7:0] ID_BASIC   = 8'h01;
  localparam logic [7:0] ID_DOCK_IR = 8'h03;
  localparam logic [7:0] ID_INERTIA = 8'h04;
  localparam logic [7:0] ID_CLIFF   = 8'h05;
  localparam logic [7:0] ID_CURRENT = 8'h06;
  localparam logic [7:0] ID_HW_VER  = 8'h0A;
  localparam logic [7:0] ID_FW_VER  = 8'h0B;
  localparam logic [7:0] ID_GYRO    = 8'h0D;
  localparam logic [7:0] ID_GPIO    = 8'h10;
  localparam logic [7:0] ID_UUID    = 8'h13;
  localparam logic [7:0] ID_CTRL    = 8'h15;

  // Charger byte codes
  localparam logic [7:0] CHG_DISCHARGING     = 8'd0;
  localparam logic [7:0] CHG_DOCK_CHARGED    = 8'd2;
  localparam logic [7:0] CHG_DOCK_CHARGING   = 8'd6;
  localparam logic [7:0] CHG_ADAPT_CHARGED   = 8'd18;
  localparam logic [7:0] CHG_ADAPT_CHARGING  = 8'd22;

  typedef logic [RecBytes-1:0][7:0] rec_t;

  typedef struct packed {
    event_t ev;
    rec_t   rec;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  // len mod 6 == 2, via reciprocal multiply (exact for 8-bit len)
  function automatic logic mod6_is_two(input logic [7:0] len);
    logic [15:0] prod;
    logic [5:0]  quo;
    logic [8:0]  quo6;
    logic [8:0]  rem;
    prod = 16'(len) * 16'd171;
    quo  = prod[15:10];
    quo6 = 9'(quo) * 9'd6;
    rem  = {1'b0, len} - quo6;
    return rem == 9'd2;
  endfunction

  // Allowed length per id; unknown ids take any length
  function automatic logic length_ok(input logic [7:0] id, input logic [7:0] len);
    logic ok;
    case (id)
      ID_BASIC:   ok = (len == 8'h0F);
      ID_DOCK_IR: ok = (len == 8'h03);
      ID_INERTIA: ok = (len == 8'h07);
      ID_CLIFF:   ok = (len == 8'h06);
      ID_CURRENT: ok = (len == 8'h02);
      ID_HW_VER:  ok = (len == 8'h04);
      ID_FW_VER:  ok = (len == 8'h04);
      ID_GYRO:    ok = mod6_is_two(len);
      ID_GPIO:    ok = (len == 8'h10);
      ID_UUID:    ok = (len == 8'h0C);
      ID_CTRL:    ok = (len == 8'h15);
      default:    ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/core/rspp_if.sv
// ----------------------------------------------------------------------------
// rspp_if: byte and result channels of the sensor packet parser
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rspp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       packet_start;

  modport source (output valid, frame_byte, packet_start, input ready);
  modport sink   (input valid, frame_byte, packet_start, output ready);
endinterface

interface rspp_out_if;
  logic                 valid;
  logic                 ready;
  rspp_pkg::event_t     event_res;
  logic [15:0]          word0;
  logic [15:0]          word1;
  logic [15:0]          word2;
  logic signed [7:0]    left_pwm;
  logic signed [7:0]    right_pwm;
  logic [2:0]           bump_bits;
  logic [1:0]           wheeldrop_bits;
  logic [2:0]           cliff_bits;
  logic [2:0]           button_bits;
  logic [2:0]           charge_state;
  logic [1:0]           overcurrent_bits;

  modport source (output valid, event_res, word0, word1, word2, left_pwm, right_pwm,
                  bump_bits, wheeldrop_bits, cliff_bits, button_bits, charge_state,
                  overcurrent_bits, input ready);
  modport sink   (input valid, event_res, word0, word1, word2, left_pwm, right_pwm,
                  bump_bits, wheeldrop_bits, cliff_bits, button_bits, charge_state,
                  overcurrent_bits, output ready);
endinterface

FILE: rtl/core/rspp_front.sv
// ----------------------------------------------------------------------------
// rspp_front: packet framing and sub-payload classification
// Tracks the frame position and sub-payload phase, gathers record bytes and
// pushes one queue entry for every byte that raises an event.
// ----------------------------------------------------------------------------
module rspp_front (
  input  logic            clk,
  input  logic            rst,
  rspp_in_if.sink         frame,
  output rspp_pkg::slot_t push,
  input  logic            push_ready
);

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  localparam logic [8:0] PosMax = 9'd511;

  logic [8:0]  frame_pos, frame_pos_next;
  logic [7:0]  payload_len, payload_len_next;
  phase_t      sub_phase, sub_phase_next;
  logic [7:0]  sub_id, sub_id_next;
  logic [7:0]  sub_len, sub_len_next;
  logic [7:0]  sub_index, sub_index_next;
  logic        abort_flag, abort_flag_next;
  rspp_pkg::rec_t record;
  rspp_pkg::rec_t rec_snap;
  logic        rec_we;
  logic        beat;
  logic [9:0]  pos_ext;
  logic [9:0]  last_pos;
  logic [7:0]  idx_inc;

  assign frame.ready = push_ready;
  assign beat        = frame.valid && frame.ready;
  assign pos_ext     = {1'b0, frame_pos};
  assign last_pos    = {2'b0, payload_len} + 10'd2;
  assign idx_inc     = sub_index + 8'd1;

  // Record with the current data byte merged in
  always_comb begin
    rec_we   = (sub_phase == PH_DATA) && !abort_flag &&
               (sub_index < 8'(rspp_pkg::RecBytes));
    rec_snap = record;
    if (rec_we) begin
      rec_snap[sub_index[rspp_pkg::RecIdxW-1:0]] = frame.frame_byte;
    end
  end

  // Classify the beat
  always_comb begin
    frame_pos_next   = frame_pos;
    payload_len_next = payload_len;
    sub_phase_next   = sub_phase;
    sub_id_next      = sub_id;
    sub_len_next     = sub_len;
    sub_index_next   = sub_index;
    abort_flag_next  = abort_flag;
    push.valid       = 1'b0;
    push.entry.ev    = rspp_pkg::EV_END;
    push.entry.rec   = rec_snap;

    if (beat) begin
      if (frame.packet_start) begin
        frame_pos_next  = 9'd1;
        sub_phase_next  = PH_ID;
        sub_id_next     = '0;
        sub_len_next    = '0;
        sub_index_next  = '0;
        abort_flag_next = 1'b0;
      end else begin
        if (frame_pos < PosMax) begin
          frame_pos_next = frame_pos + 9'd1;
        end
        if (frame_pos == 9'd2) begin
          payload_len_next = frame.frame_byte;
          sub_phase_next   = PH_ID;
          sub_id_next      = '0;
          sub_len_next     = '0;
          sub_index_next   = '0;
          abort_flag_next  = 1'b0;
        end else if (frame_pos >= 9'd3 && pos_ext <= last_pos) begin
          if (!abort_flag) begin
            case (sub_phase)
              PH_ID: begin
                sub_id_next    = frame.frame_byte;
                sub_phase_next = PH_LEN;
              end
              PH_LEN: begin
                sub_len_next   = frame.frame_byte;
                sub_index_next = '0;
                if (!rspp_pkg::length_ok(sub_id, frame.frame_byte)) begin
                  abort_flag_next = 1'b1;
                  sub_phase_next  = PH_ID;
                  push.valid      = 1'b1;
                  push.entry.ev   = rspp_pkg::EV_LEN_ERR;
                end else begin
                  sub_phase_next = (frame.frame_byte == 8'd0) ? PH_ID : PH_DATA;
                end
              end
              PH_DATA: begin
                sub_index_next = idx_inc;
                if (idx_inc == sub_len) begin
                  sub_phase_next = PH_ID;
                  if (sub_id == rspp_pkg::ID_BASIC) begin
                    push.valid    = 1'b1;
                    push.entry.ev = rspp_pkg::EV_BASIC;
                  end else if (sub_id == rspp_pkg::ID_CLIFF) begin
                    push.valid    = 1'b1;
                    push.entry.ev = rspp_pkg::EV_CLIFF;
                  end
                end
              end
              default: begin
                sub_phase_next = PH_ID;
              end
            endcase
          end
        end else if (pos_ext == last_pos + 10'd1) begin
          push.valid    = 1'b1;
          push.entry.ev = rspp_pkg::EV_END;
        end
      end
    end
  end

  // Hold framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos   <= '0;
      payload_len <= '0;
      sub_phase   <= PH_ID;
      sub_id      <= '0;
      sub_len     <= '0;
      sub_index   <= '0;
      abort_flag  <= 1'b0;
    end else begin
      frame_pos   <= frame_pos_next;
      payload_len <= payload_len_next;
      sub_phase   <= sub_phase_next;
      sub_id      <= sub_id_next;
      sub_len     <= sub_len_next;
      sub_index   <= sub_index_next;
      abort_flag  <= abort_flag_next;
    end
  end

  // Store record bytes
  always_ff @(posedge clk) begin
    if (beat && !frame.packet_start) begin
      record <= rec_snap;
    end
  end

endmodule

FILE: rtl/core/rspp_queue.sv
// ----------------------------------------------------------------------------
// rspp_queue: event queue between framing and result decode
// Small circular buffer of classified entries with a fill count.
// ----------------------------------------------------------------------------
module rspp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  rspp_pkg::slot_t push,
  output logic            push_ready,
  output rspp_pkg::slot_t head,
  input  logic            pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rspp_pkg::entry_t slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CntW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign push_fire  = push.valid && push_ready;
  assign pop_fire   = pop && head.valid;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  // Write entries
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

FILE: rtl/core/rspp_back.sv
// ----------------------------------------------------------------------------
// rspp_back: result decode and output register
// Pops queue entries, unpacks record fields, tracks the charger state and
// holds each result until the receiver takes the beat.
// ----------------------------------------------------------------------------
module rspp_back (
  input  logic            clk,
  input  logic            rst,
  input  rspp_pkg::slot_t head,
  output logic            pop,
  rspp_out_if.source      result
);

  logic [2:0] held_charge_state;
  logic [2:0] charge_next;
  rspp_pkg::rec_t rec;

  assign pop = head.valid && (!result.valid || result.ready);
  assign rec = head.entry.rec;

  // Map the charger byte, keep the old state on unknown codes
  always_comb begin
    case (rec[12])
      rspp_pkg::CHG_DISCHARGING:    charge_next = 3'd0;
      rspp_pkg::CHG_DOCK_CHARGED:   charge_next = 3'd1;
      rspp_pkg::CHG_DOCK_CHARGING:  charge_next = 3'd2;
      rspp_pkg::CHG_ADAPT_CHARGED:  charge_next = 3'd3;
      rspp_pkg::CHG_ADAPT_CHARGING: charge_next = 3'd4;
      default:                      charge_next = held_charge_state;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid      <= 1'b0;
      held_charge_state <= 3'd0;
    end else begin
      if (pop) begin
        result.valid <= 1'b1;
        if (head.entry.ev == rspp_pkg::EV_BASIC) begin
          held_charge_state <= charge_next;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Load the result fields
  always_ff @(posedge clk) begin
    if (pop) begin
      result.event_res        <= head.entry.ev;
      result.word0            <= '0;
      result.word1            <= '0;
      result.word2            <= '0;
      result.left_pwm         <= '0;
      result.right_pwm        <= '0;
      result.bump_bits        <= '0;
      result.wheeldrop_bits   <= '0;
      result.cliff_bits       <= '0;
      result.button_bits      <= '0;
      result.charge_state     <= '0;
      result.overcurrent_bits <= '0;
      case (head.entry.ev)
        rspp_pkg::EV_BASIC: begin
          result.word0            <= {rec[1], rec[0]};
          result.word1            <= {rec[6], rec[5]};
          result.word2            <= {rec[8], rec[7]};
          result.left_pwm         <= $signed(rec[9]);
          result.right_pwm        <= $signed(rec[10]);
          result.bump_bits        <= rec[2][2:0];
          result.wheeldrop_bits   <= rec[3][1:0];
          result.cliff_bits       <= rec[4][2:0];
          result.button_bits      <= rec[11][2:0];
          result.charge_state     <= charge_next;
          result.overcurrent_bits <= rec[13][1:0];
        end
        rspp_pkg::EV_CLIFF: begin
          result.word0 <= {rec[1], rec[0]};
          result.word1 <= {rec[3], rec[2]};
          result.word2 <= {rec[5], rec[4]};
        end
        default: begin
          result.word0 <= '0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/robot_sensor_packet_parser.sv
// ----------------------------------------------------------------------------
// robot_sensor_packet_parser: sensor feedback packet parser, top level
// Framing front end, event queue and result decode back end.
// ----------------------------------------------------------------------------
// Usage:
//   frame  - one packet byte per beat, with packet_start on the first header
//            byte. Byte 2 is the payload length; the payload is a chain of
//            id/length/data sub-payloads, then one checksum byte.
//   result - at most one result per input beat: a basic sensor record, cliff
//            signals, a length error or the payload end marker.
// Throughput is one byte per cycle while the queue has a free slot. A result
// raised by a byte goes through the queue, then the output register. The front
// end takes a byte whenever the queue has a free slot, so it keeps accepting
// while a finished result waits; the queue depth sets how many results can
// pile up before frame.ready drops.
// Reset clears framing state, the queue and the held charger state; the first
// byte after reset counts as header byte 0. A stalled receiver holds the
// result register, then fills the queue, then stalls the byte channel.
// ----------------------------------------------------------------------------
module robot_sensor_packet_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  rspp_in_if.sink    frame,
  rspp_out_if.source result
);

  rspp_pkg::slot_t push;
  rspp_pkg::slot_t head;
  logic            push_ready;
  logic            pop;

  rspp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .push       (push),
    .push_ready (push_ready)
  );

  rspp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  rspp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

`ifndef SYNTHESIS
  // An event is raised only on an accepted beat, so the queue always has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> push_ready)
    else $error("event pushed into a full queue");

  // A pop always loads the output register
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> result.valid)
    else $error("popped entry did not reach the output");

  // Basic records carry a decoded charger state
  a_charge_range: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.event_res == rspp_pkg::EV_BASIC) |->
      (result.charge_state <= 3'd4))
    else $error("charger state out of range");

  // Non-basic results leave the record fields at zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.event_res != rspp_pkg::EV_BASIC) |->
      (result.left_pwm == 8'sd0 && result.right_pwm == 8'sd0 &&
       result.bump_bits == 3'd0 && result.charge_state == 3'd0))
    else $error("record fields set on a non-basic result");
`endif

endmodule

FILE: bench/tb_robot_sensor_packet_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_robot_sensor_packet_parser: bench for the sensor packet parser
// Feeds whole packets byte by byte, plus broken packets and stray bytes. A
// byte-level shadow of the parser forecasts each result, and every result
// beat is compared field by field, in order. Both channels idle at random,
// and a long receiver hold-off backs the parser up into its input.
// ----------------------------------------------------------------------------
module tb_robot_sensor_packet_parser;
  import rspp_pkg::*;

  localparam int        QUIET_LIMIT = 4000;
  localparam int        HOLD_CYCLES = 400;
  localparam int        RAND_BYTES  = 150;
  localparam logic [8:0] POS_SAT    = 9'd511;

  // Charger states as reported in a basic record
  localparam logic [2:0] CS_DISCHARGING    = 3'd0;
  localparam logic [2:0] CS_DOCK_CHARGED   = 3'd1;
  localparam logic [2:0] CS_DOCK_CHARGING  = 3'd2;
  localparam logic [2:0] CS_ADAPT_CHARGED  = 3'd3;
  localparam logic [2:0] CS_ADAPT_CHARGING = 3'd4;

  typedef enum logic [1:0] {AWAIT_ID, AWAIT_LEN, AWAIT_DATA} sub_phase_t;
  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

  typedef struct packed {
    event_t             ev;
    logic [15:0]        w0;
    logic [15:0]        w1;
    logic [15:0]        w2;
    logic signed [7:0]  lpwm;
    logic signed [7:0]  rpwm;
    logic [2:0]         bump;
    logic [1:0]         drop;
    logic [2:0]         cliff;
    logic [2:0]         btn;
    logic [2:0]         chg;
    logic [1:0]         oc;
  } sensor_result_t;

  logic clk = 1'b0;
  logic rst;

  rspp_in_if  byte_ch ();
  rspp_out_if res_ch ();

  robot_sensor_packet_parser uut (
    .clk    (clk),
    .rst    (rst),
    .frame  (byte_ch),
    .result (res_ch)
  );

  always #6 clk = ~clk;

  // Parser shadow state
  logic [8:0]  pkt_pos;
  logic [7:0]  pay_len;
  sub_phase_t  phase;
  logic [7:0]  cur_id;
  logic [7:0]  cur_len;
  logic [7:0]  data_idx;
  logic        dropping;
  logic [7:0]  rec_shadow [15];
  logic [2:0]  held_chg;

  sensor_result_t expected_events[$];
  logic [7:0]     payload[$];

  logic [7:0] known_ids [11] = '{ID_BASIC, ID_DOCK_IR, ID_INERTIA, ID_CLIFF, ID_CURRENT,
                                 ID_HW_VER, ID_FW_VER, ID_GYRO, ID_GPIO, ID_UUID, ID_CTRL};
  logic [7:0] chg_codes [5] = '{CHG_DISCHARGING, CHG_DOCK_CHARGED, CHG_DOCK_CHARGING,
                                CHG_ADAPT_CHARGED, CHG_ADAPT_CHARGING};

  int  failures;
  int  bytes_sent;
  int  packets_sent;
  int  burst_left;
  bit  gaps_on;
  int  hold_reqs;
  int  holds_done;
  int  quiet;
  int  seen [4];

  // ---------------------------------------------------------------------------
  // Shadow parser: advance on one accepted byte, queue the result it raises
  // ---------------------------------------------------------------------------
  function automatic void clear_sub();
    phase    = AWAIT_ID;
    cur_id   = '0;
    cur_len  = '0;
    data_idx = '0;
    dropping = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic start);
    sensor_result_t r;
    logic           emit;
    logic           ok;
    int             pos;
    r    = '0;
    emit = 1'b0;
    if (start) begin
      pkt_pos = '0;
      clear_sub();
    end
    pos = int'(pkt_pos);
    if (pos == 2) begin
      pay_len = b;
      clear_sub();
    end else if (pos >= 3 && pos <= int'(pay_len) + 2) begin
      if (!dropping) begin
        case (phase)
          AWAIT_ID: begin
            cur_id = b;
            phase  = AWAIT_LEN;
          end
          AWAIT_LEN: begin
            cur_len  = b;
            data_idx = '0;
            case (cur_id)
              ID_BASIC:   ok = (b == 8'd15);
              ID_DOCK_IR: ok = (b == 8'd3);
              ID_INERTIA: ok = (b == 8'd7);
              ID_CLIFF:   ok = (b == 8'd6);
              ID_CURRENT: ok = (b == 8'd2);
              ID_HW_VER:  ok = (b == 8'd4);
              ID_FW_VER:  ok = (b == 8'd4);
              ID_GYRO:    ok = ((int'(b) % 6) == 2);
              ID_GPIO:    ok = (b == 8'd16);
              ID_UUID:    ok = (b == 8'd12);
              ID_CTRL:    ok = (b == 8'd21);
              default:    ok = 1'b1;
            endcase
            // a bad length kills the rest of the payload
            if (!ok) begin
              dropping = 1'b1;
              phase    = AWAIT_ID;
              r.ev     = EV_LEN_ERR;
              emit     = 1'b1;
            end else begin
              phase = (b == 8'd0) ? AWAIT_ID : AWAIT_DATA;
            end
          end
          default: begin
            if (data_idx < 8'd15) rec_shadow[data_idx] = b;
            data_idx = data_idx + 8'd1;
            if (data_idx == cur_len) begin
              phase = AWAIT_ID;
              if (cur_id == ID_BASIC) begin
                // unknown charger codes keep the last state
                case (rec_shadow[12])
                  CHG_DISCHARGING:    held_chg = CS_DISCHARGING;
                  CHG_DOCK_CHARGED:   held_chg = CS_DOCK_CHARGED;
                  CHG_DOCK_CHARGING:  held_chg = CS_DOCK_CHARGING;
                  CHG_ADAPT_CHARGED:  held_chg = CS_ADAPT_CHARGED;
                  CHG_ADAPT_CHARGING: held_chg = CS_ADAPT_CHARGING;
                  default: ;
                endcase
                r.ev    = EV_BASIC;
                r.w0    = {rec_shadow[1], rec_shadow[0]};
                r.w1    = {rec_shadow[6], rec_shadow[5]};
                r.w2    = {rec_shadow[8], rec_shadow[7]};
                r.lpwm  = rec_shadow[9];
                r.rpwm  = rec_shadow[10];
                r.bump  = rec_shadow[2][2:0];
                r.drop  = rec_shadow[3][1:0];
                r.cliff = rec_shadow[4][2:0];
                r.btn   = rec_shadow[11][2:0];
                r.chg   = held_chg;
                r.oc    = rec_shadow[13][1:0];
                emit    = 1'b1;
              end else if (cur_id == ID_CLIFF) begin
                r.ev = EV_CLIFF;
                r.w0 = {rec_shadow[1], rec_shadow[0]};
                r.w1 = {rec_shadow[3], rec_shadow[2]};
                r.w2 = {rec_shadow[5], rec_shadow[4]};
                emit = 1'b1;
              end
            end
          end
        endcase
      end
    end else if (pos == int'(pay_len) + 3) begin
      r.ev = EV_END;
      emit = 1'b1;
    end
    if (pkt_pos != POS_SAT) pkt_pos = pkt_pos + 9'd1;
    if (emit) expected_events.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Packet building
  // ---------------------------------------------------------------------------
  // legal length of a known id, -1 for an unknown id
  function automatic int legal_len(input logic [7:0] id);
    case (id)
      ID_BASIC:   return 15;
      ID_DOCK_IR: return 3;
      ID_INERTIA: return 7;
      ID_CLIFF:   return 6;
      ID_CURRENT: return 2;
      ID_HW_VER:  return 4;
      ID_FW_VER:  return 4;
      ID_GYRO:    return 2 + 6 * $urandom_range(0, 3);
      ID_GPIO:    return 16;
      ID_UUID:    return 12;
      ID_CTRL:    return 21;
      default:    return -1;
    endcase
  endfunction

  // fill < 0 gives random data bytes
  function automatic void add_sub(input logic [7:0] id, input logic [7:0] len, input int fill);
    payload.push_back(id);
    payload.push_back(len);
    for (int i = 0; i < int'(len); i++)
      payload.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endfunction

  // overwrite the charger byte of the basic record just added
  function automatic void set_charge(input logic [7:0] code);
    payload[payload.size() - 3] = code;
  endfunction

  function automatic logic [7:0] unknown_id();
    logic [7:0] id;
    id = 8'($urandom);
    while (legal_len(id) >= 0) id = 8'($urandom);
    return id;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte channel: bursts with random gaps, one beat per call
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.frame_byte   <= b;
    byte_ch.packet_start <= start;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b, start);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // header, length byte, payload (cut or padded to plen), checksum
  task automatic send_packet(input logic lead_start, input int plen);
    send_byte(8'($urandom), lead_start);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'(plen), 1'b0);
    for (int i = 0; i < plen; i++)
      send_byte(i < payload.size() ? payload[i] : 8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    payload.delete();
    packets_sent++;
  endtask

  task automatic send_junk(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: stall pattern, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink_driver
    sink_mode_t mode;
    int         mode_left;
    int         tick;
    res_ch.ready = 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_reqs) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        tick++;
        case (mode)
          SINK_OPEN:   res_ch.ready <= 1'b1;
          SINK_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: res_ch.ready <= (tick % 4 == 0);
          default:     res_ch.ready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each beat against the oldest forecast
  // ---------------------------------------------------------------------------
  function automatic string show(input sensor_result_t r);
    return $sformatf("%s w0=%h w1=%h w2=%h pwm=%0d/%0d bump=%0d drop=%0d cliff=%0d btn=%0d chg=%0d oc=%0d",
                     r.ev.name(), r.w0, r.w1, r.w2, r.lpwm, r.rpwm, r.bump, r.drop,
                     r.cliff, r.btn, r.chg, r.oc);
  endfunction

  always @(posedge clk) begin
    sensor_result_t got;
    sensor_result_t want;
    string          diff;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.ev    = res_ch.event_res;
      got.w0    = res_ch.word0;
      got.w1    = res_ch.word1;
      got.w2    = res_ch.word2;
      got.lpwm  = res_ch.left_pwm;
      got.rpwm  = res_ch.right_pwm;
      got.bump  = res_ch.bump_bits;
      got.drop  = res_ch.wheeldrop_bits;
      got.cliff = res_ch.cliff_bits;
      got.btn   = res_ch.button_bits;
      got.chg   = res_ch.charge_state;
      got.oc    = res_ch.overcurrent_bits;
      if (expected_events.size() == 0) begin
        failures++;
        if (failures <= 10) $display("%0t: result with none pending: %s", $realtime, show(got));
      end else begin
        want = expected_events.pop_front();
        diff = "";
        if (got.ev    !== want.ev)    diff = {diff, " event_res"};
        if (got.w0    !== want.w0)    diff = {diff, " word0"};
        if (got.w1    !== want.w1)    diff = {diff, " word1"};
        if (got.w2    !== want.w2)    diff = {diff, " word2"};
        if (got.lpwm  !== want.lpwm)  diff = {diff, " left_pwm"};
        if (got.rpwm  !== want.rpwm)  diff = {diff, " right_pwm"};
        if (got.bump  !== want.bump)  diff = {diff, " bump_bits"};
        if (got.drop  !== want.drop)  diff = {diff, " wheeldrop_bits"};
        if (got.cliff !== want.cliff) diff = {diff, " cliff_bits"};
        if (got.btn   !== want.btn)   diff = {diff, " button_bits"};
        if (got.chg   !== want.chg)   diff = {diff, " charge_state"};
        if (got.oc    !== want.oc)    diff = {diff, " overcurrent_bits"};
        if (diff != "") begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: mismatch in%s", $realtime, diff);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end else begin
          seen[want.ev]++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results pending",
               QUIET_LIMIT, expected_events.size());
      $display("[robot_sensor_packet_parser] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // first packet after reset carries no start flag
  task automatic test_first_packet_no_start();
    add_sub(ID_BASIC, 8'd15, 8'hFF);
    set_charge(CHG_ADAPT_CHARGING);
    add_sub(ID_CLIFF, 8'd6, 8'h00);
    send_packet(1'b0, payload.size());
  endtask

  // field extremes, four of the five charger codes and an unknown code
  task automatic test_record_decode();
    add_sub(ID_BASIC, 8'd15, 8'h00);
    add_sub(ID_BASIC, 8'd15, 8'h80);
    set_charge(CHG_ADAPT_CHARGED);
    add_sub(ID_BASIC, 8'd15, 8'h7F);
    set_charge(CHG_DOCK_CHARGING);
    send_packet(1'b1, payload.size());
    add_sub(ID_BASIC, 8'd15, -1);
    set_charge(CHG_DOCK_CHARGED);
    add_sub(ID_BASIC, 8'd15, -1);
    set_charge(8'h07);
    add_sub(ID_CLIFF, 8'd6, 8'hFF);
    send_packet(1'b1, payload.size());
  endtask

  task automatic test_length_rules();
    // empty payload
    send_packet(1'b1, 0);
    // bad length on each known id: the cliff record behind it is dropped
    for (int k = 0; k < 11; k++) begin
      add_sub(ID_CLIFF, 8'd6, -1);
      add_sub(known_ids[k], 8'(legal_len(known_ids[k]) + 1), -1);
      add_sub(ID_CLIFF, 8'd6, -1);
      send_packet(1'b1, payload.size());
    end
    // unknown ids skipped, zero length, good lengths on silent ids
    add_sub(unknown_id(), 8'd0, -1);
    add_sub(unknown_id(), 8'd5, -1);
    add_sub(ID_GYRO, 8'd2, -1);
    add_sub(ID_GYRO, 8'd8, -1);
    add_sub(ID_DOCK_IR, 8'd3, -1);
    add_sub(ID_CTRL, 8'd21, -1);
    add_sub(ID_CLIFF, 8'd6, -1);
    send_packet(1'b1, payload.size());
    // gyro of length zero is rejected
    add_sub(ID_GYRO, 8'd0, -1);
    send_packet(1'b1, payload.size());
  endtask

  task automatic test_truncation();
    add_sub(ID_BASIC, 8'd15, -1);
    send_packet(1'b1, 9);
    add_sub(ID_CLIFF, 8'd6, -1);
    add_sub(ID_CLIFF, 8'd6, -1);
    send_packet(1'b1, 9);
    add_sub(ID_CLIFF, 8'd6, -1);
    add_sub(ID_CLIFF, 8'd6, -1);
    send_packet(1'b1, 10);
  endtask

  task automatic test_restart_and_trailer();
    // abandon a packet halfway through a basic record
    send_byte(8'($urandom), 1'b1);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'd40, 1'b0);
    send_byte(ID_BASIC, 1'b0);
    send_byte(8'd15, 1'b0);
    send_junk(6);
    add_sub(ID_CLIFF, 8'd6, -1);
    send_packet(1'b1, payload.size());
    // longest payload, gyro data cut off by the payload end
    add_sub(ID_GYRO, 8'd254, -1);
    send_packet(1'b1, 255);
    // trailer past the position limit, then a packet without start
    send_junk(260);
    add_sub(ID_CLIFF, 8'd6, -1);
    send_packet(1'b0, payload.size());
    add_sub(ID_BASIC, 8'd15, -1);
    send_packet(1'b1, payload.size());
  endtask

  // hold the receiver off while full packets keep coming
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_reqs++;
    for (int p = 0; p < 3; p++) begin
      add_sub(ID_BASIC, 8'd15, -1);
      add_sub(ID_CLIFF, 8'd6, -1);
      add_sub(ID_BASIC, 8'd15, -1);
      send_packet(1'b1, payload.size());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_packets();
    int         rand_bytes;
    int         nsub;
    int         r;
    int         kind;
    int         plen;
    logic [7:0] id;
    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      if (kind == 0) begin
        add_sub(ID_GYRO, 8'd254, -1);
        plen = 255;
      end else begin
        nsub = $urandom_range(0, 4);
        for (int s = 0; s < nsub; s++) begin
          r = $urandom_range(0, 99);
          if (r < 30) begin
            add_sub(ID_BASIC, 8'd15, -1);
            if ($urandom_range(0, 9) != 0) set_charge(chg_codes[$urandom_range(0, 4)]);
          end else if (r < 55) begin
            add_sub(ID_CLIFF, 8'd6, -1);
          end else if (r < 75) begin
            id = known_ids[$urandom_range(0, 10)];
            add_sub(id, 8'(legal_len(id)), -1);
          end else if (r < 90) begin
            add_sub(unknown_id(), 8'($urandom_range(0, 6)), -1);
          end else begin
            id = known_ids[$urandom_range(0, 10)];
            add_sub(id, 8'(legal_len(id) + $urandom_range(1, 3)), -1);
          end
        end
        plen = payload.size();
        // cut short, or pad with random bytes
        if (kind < 12 && plen > 0) plen = $urandom_range(0, plen - 1);
        else if (kind < 17) plen = plen + $urandom_range(1, 8);
      end
      if (kind >= 95) begin
        send_packet(1'b0, plen);
      end else begin
        send_packet(1'b1, plen);
        rand_bytes += plen + 4;
      end
      if ($urandom_range(0, 99) < 15) send_junk($urandom_range(1, 4));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    byte_ch.valid        = 1'b0;
    byte_ch.frame_byte   = 8'h00;
    byte_ch.packet_start = 1'b0;
    rst        = 1'b1;
    bytes_sent = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    pkt_pos    = '0;
    pay_len    = '0;
    held_chg   = CS_DISCHARGING;
    clear_sub();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_packet_no_start();
    test_record_decode();
    test_length_rules();
    test_truncation();
    test_restart_and_trailer();
    test_backpressure();
    test_random_packets();

    // drain, then watch for stray results
    byte_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d packets in %0d bytes, %0d receiver hold-offs", packets_sent,
             bytes_sent, holds_done);
    $display("Matched %0d basic, %0d cliff, %0d length-error, %0d end results; %0d failures",
             seen[EV_BASIC], seen[EV_CLIFF], seen[EV_LEN_ERR], seen[EV_END], failures);
    if (failures == 0) begin
      $display("[robot_sensor_packet_parser] OK");
    end else begin
      $display("[robot_sensor_packet_parser] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rspp_pkg.sv
rtl/core/rspp_if.sv
rtl/core/rspp_front.sv
rtl/core/rspp_queue.sv
rtl/core/rspp_back.sv
rtl/core/robot_sensor_packet_parser.sv
bench/tb_robot_sensor_packet_parser.sv
